// ----- src/euler_to_quaternion_defines.svh -----
// Assertion macros shared by the euler_to_quaternion RTL.
`ifndef EULER_TO_QUATERNION_DEFINES_SVH
`define EULER_TO_QUATERNION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge of clk_i outside reset.
`define E2Q_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication: the consequent is checked through ##n after the antecedent.
`define E2Q_ASSERT_DLY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ----- src/e2q_pkg.sv -----
// Shared types, constants and tables for the Euler angle to quaternion converter.
package e2q_pkg;

  localparam int unsigned INT_FRAC        = 30;
  localparam int unsigned CORDIC_STEPS    = 30;
  localparam int unsigned ITERS_PER_STAGE = 2;
  localparam int unsigned CORDIC_STAGES   = CORDIC_STEPS / ITERS_PER_STAGE;

  // Width of the internal Q.30 trig values and of the pair sums.
  localparam int unsigned TW = 34;
  localparam int unsigned SW = TW + 1;

  localparam int unsigned NUM_LANES  = 3;
  localparam int unsigned LANE_PITCH = 0;
  localparam int unsigned LANE_YAW   = 1;
  localparam int unsigned LANE_ROLL  = 2;

  localparam int unsigned NUM_COMPS = 4;
  localparam int unsigned COMP_W    = 0;
  localparam int unsigned COMP_X    = 1;
  localparam int unsigned COMP_Y    = 2;
  localparam int unsigned COMP_Z    = 3;

  // Pipeline depths outside the angle reduction stages.
  localparam int unsigned TRIG_FIXED_LAT = CORDIC_STAGES + 4;
  localparam int unsigned MIX_LAT        = 5;

  localparam logic [63:0] PI_Q30          = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [63:0] TWO_PI_Q30      = 64'd6746518852;
  localparam logic [63:0] CORDIC_GAIN_Q30 = 64'd652032874;

  typedef struct packed {
    logic signed [TW-1:0] c;
    logic signed [TW-1:0] s;
  } trig_t;

  typedef struct packed {
    logic signed [TW-1:0] x;
    logic signed [TW-1:0] y;
    logic signed [TW-1:0] z;
    logic                 flip;
  } cordic_t;

  // Number of conditional 2*pi*2^k subtractions needed to bring the half angle below 2*pi.
  function automatic int unsigned red_steps(input int unsigned angle_frac_bits);
    return (angle_frac_bits < 12) ? (12 - angle_frac_bits) : 0;
  endfunction

  function automatic logic signed [TW-1:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h3243F6A8;
      5'd1:    v = 32'h1DAC6705;
      5'd2:    v = 32'h0FADBAFC;
      5'd3:    v = 32'h07F56EA6;
      5'd4:    v = 32'h03FEAB76;
      5'd5:    v = 32'h01FFD55B;
      5'd6:    v = 32'h00FFFAAA;
      5'd7:    v = 32'h007FFF55;
      5'd8:    v = 32'h003FFFEA;
      5'd9:    v = 32'h001FFFFD;
      5'd10:   v = 32'h000FFFFF;
      5'd11:   v = 32'h0007FFFF;
      5'd12:   v = 32'h0003FFFF;
      5'd13:   v = 32'h0001FFFF;
      5'd14:   v = 32'h0000FFFF;
      5'd15:   v = 32'h00007FFF;
      5'd16:   v = 32'h00003FFF;
      5'd17:   v = 32'h00001FFF;
      5'd18:   v = 32'h00000FFF;
      5'd19:   v = 32'h000007FF;
      5'd20:   v = 32'h000003FF;
      5'd21:   v = 32'h000001FF;
      5'd22:   v = 32'h000000FF;
      5'd23:   v = 32'h0000007F;
      5'd24:   v = 32'h0000003F;
      5'd25:   v = 32'h0000001F;
      5'd26:   v = 32'h0000000F;
      5'd27:   v = 32'h00000008;
      5'd28:   v = 32'h00000004;
      5'd29:   v = 32'h00000002;
      default: v = 32'h00000000;
    endcase
    return signed'({{(TW-32){1'b0}}, v});
  endfunction

endpackage

// ----- src/e2q_trig.sv -----
// Three-lane pipeline: half-angle reduction, folding and CORDIC cosine/sine.
`include "euler_to_quaternion_defines.svh"

module e2q_trig #(
  parameter int unsigned ANGLE_FRAC_BITS = 13
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic signed [15:0]  angle_i [e2q_pkg::NUM_LANES],
  output logic                vld_o,
  output e2q_pkg::trig_t      trig_o [e2q_pkg::NUM_LANES]
);

  localparam int unsigned TW        = e2q_pkg::TW;
  localparam int unsigned NL        = e2q_pkg::NUM_LANES;
  localparam int unsigned NCS       = e2q_pkg::CORDIC_STAGES;
  localparam int unsigned IPS       = e2q_pkg::ITERS_PER_STAGE;
  localparam int unsigned HW        = 45 - ANGLE_FRAC_BITS;
  localparam int unsigned RW        = (HW > 35) ? HW : 35;
  localparam int unsigned PRE_SHIFT = 29 - ANGLE_FRAC_BITS;
  localparam int unsigned RED       = e2q_pkg::red_steps(ANGLE_FRAC_BITS);
  localparam int unsigned LAT       = RED + e2q_pkg::TRIG_FIXED_LAT;

  localparam logic [RW-1:0] TWO_PI_R   = RW'(e2q_pkg::TWO_PI_Q30);
  localparam logic [TW-1:0] TWO_PI_T   = TW'(e2q_pkg::TWO_PI_Q30);
  localparam logic [TW-1:0] PI_T       = TW'(e2q_pkg::PI_Q30);
  localparam logic [TW-1:0] HALF_PI_T  = TW'(e2q_pkg::HALF_PI_Q30);
  localparam logic [TW-1:0] WRAP_LIM_T = TW'(e2q_pkg::TWO_PI_Q30 - e2q_pkg::HALF_PI_Q30);
  localparam logic [TW-1:0] GAIN_T     = TW'(e2q_pkg::CORDIC_GAIN_Q30);

  // Valid bit of every stage; tap k belongs to the k-th register stage.
  logic [LAT-1:0] vld_q;

  logic [RW-1:0]         mag_q [RED+1][NL];
  logic                  neg_q [RED+1][NL];
  logic [RW-1:0]         mag_d [NL];
  logic [TW-1:0]         zu_q  [NL];
  logic [TW-1:0]         zu_d  [NL];
  e2q_pkg::cordic_t      cs_q  [NCS+1][NL];
  e2q_pkg::cordic_t      fold_d [NL];
  e2q_pkg::trig_t        trig_q [NL];
  e2q_pkg::trig_t        trig_d [NL];

  function automatic e2q_pkg::cordic_t rotate(input e2q_pkg::cordic_t a, input logic [4:0] idx);
    logic signed [TW-1:0] ax;
    logic signed [TW-1:0] ay;
    logic signed [TW-1:0] dx;
    logic signed [TW-1:0] dy;
    e2q_pkg::cordic_t     r;
    ax = a.x;
    ay = a.y;
    dx = ay >>> idx;
    dy = ax >>> idx;
    r  = a;
    if (!a.z[TW-1]) begin
      r.x = ax - dx;
      r.y = ay + dy;
      r.z = a.z - e2q_pkg::atan_q30(idx);
    end else begin
      r.x = ax + dx;
      r.y = ay - dy;
      r.z = a.z + e2q_pkg::atan_q30(idx);
    end
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], vld_i};
    end
  end

  // Half angle in Q.30, kept as sign and magnitude for the reduction.
  always_comb begin
    logic [RW-1:0] h;
    for (int l = 0; l < NL; l++) begin
      h        = {{(RW-16){angle_i[l][15]}}, angle_i[l]} << PRE_SHIFT;
      mag_d[l] = angle_i[l][15] ? (~h + RW'(1)) : h;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < NL; l++) begin
      mag_q[0][l] <= mag_d[l];
      neg_q[0][l] <= angle_i[l][15];
    end
  end

  for (genvar g = 0; g < RED; g++) begin : g_red
    localparam logic [RW-1:0] STEP_K = RW'(e2q_pkg::TWO_PI_Q30 << (RED - 1 - g));
    always_ff @(posedge clk_i) begin
      for (int l = 0; l < NL; l++) begin
        mag_q[g+1][l] <= (mag_q[g][l] >= STEP_K) ? (mag_q[g][l] - STEP_K) : mag_q[g][l];
        neg_q[g+1][l] <= neg_q[g][l];
      end
    end
  end

  // The magnitude is now below 2*pi; a negative angle takes the complement.
  always_comb begin
    logic [TW-1:0] m;
    for (int l = 0; l < NL; l++) begin
      m = TW'(mag_q[RED][l]);
      zu_d[l] = (neg_q[RED][l] && (m != '0)) ? (TWO_PI_T - m) : m;
    end
  end

  always_ff @(posedge clk_i) begin
    zu_q <= zu_d;
  end

  // Fold [0, 2*pi) into [-pi/2, pi/2]; the middle band shifts by pi and flips both signs.
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      fold_d[l].x = signed'(GAIN_T);
      fold_d[l].y = '0;
      if (zu_q[l] <= HALF_PI_T) begin
        fold_d[l].z    = signed'(zu_q[l]);
        fold_d[l].flip = 1'b0;
      end else if (zu_q[l] < WRAP_LIM_T) begin
        fold_d[l].z    = signed'(zu_q[l] - PI_T);
        fold_d[l].flip = 1'b1;
      end else begin
        fold_d[l].z    = signed'(zu_q[l] - TWO_PI_T);
        fold_d[l].flip = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cs_q[0] <= fold_d;
  end

  for (genvar g = 0; g < NCS; g++) begin : g_cordic
    e2q_pkg::cordic_t cs_d [NL];
    always_comb begin
      for (int l = 0; l < NL; l++) begin
        cs_d[l] = cs_q[g][l];
        for (int k = 0; k < IPS; k++) begin
          cs_d[l] = rotate(cs_d[l], 5'(g * IPS + k));
        end
      end
    end
    always_ff @(posedge clk_i) begin
      cs_q[g+1] <= cs_d;
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      trig_d[l].c = cs_q[NCS][l].flip ? -cs_q[NCS][l].x : cs_q[NCS][l].x;
      trig_d[l].s = cs_q[NCS][l].flip ? -cs_q[NCS][l].y : cs_q[NCS][l].y;
    end
  end

  always_ff @(posedge clk_i) begin
    trig_q <= trig_d;
  end

  assign vld_o  = vld_q[LAT-1];
  assign trig_o = trig_q;

  `E2Q_ASSERT_IMP(a_red_below_two_pi, vld_q[RED],
    (mag_q[RED][0] < TWO_PI_R) && (mag_q[RED][1] < TWO_PI_R) && (mag_q[RED][2] < TWO_PI_R),
    "reduced half angle not below 2*pi")
  `E2Q_ASSERT_IMP(a_fold_in_range, vld_q[RED+2],
    (cs_q[0][0].z <= signed'(HALF_PI_T)) && (cs_q[0][0].z >= -signed'(HALF_PI_T)) &&
    (cs_q[0][1].z <= signed'(HALF_PI_T)) && (cs_q[0][1].z >= -signed'(HALF_PI_T)) &&
    (cs_q[0][2].z <= signed'(HALF_PI_T)) && (cs_q[0][2].z >= -signed'(HALF_PI_T)),
    "folded angle outside minus pi/2 to pi/2")
  `E2Q_ASSERT_IMP(a_trig_latency, vld_o, $past(vld_i, LAT),
    "trig output beat without a matching input beat")

endmodule

// ----- src/e2q_mix.sv -----
// Triple products of the half-angle cosines and sines and their pair sums.
module e2q_mix (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  e2q_pkg::trig_t                 trig_i [e2q_pkg::NUM_LANES],
  output logic                           vld_o,
  output logic signed [e2q_pkg::SW-1:0]  sum_o  [e2q_pkg::NUM_COMPS]
);

  localparam int unsigned TW  = e2q_pkg::TW;
  localparam int unsigned SW  = e2q_pkg::SW;
  localparam int unsigned PW  = 2 * TW;
  localparam int unsigned LAT = e2q_pkg::MIX_LAT;

  localparam logic signed [PW-1:0] HALF_LSB = PW'(64'd1 << (e2q_pkg::INT_FRAC - 1));

  // Roll-pitch pairs: cos*cos, sin*sin, sin*cos, cos*sin.
  localparam int unsigned RP_CC = 0;
  localparam int unsigned RP_SS = 1;
  localparam int unsigned RP_SC = 2;
  localparam int unsigned RP_CS = 3;

  function automatic logic signed [TW-1:0] round_q30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + HALF_LSB) >>> e2q_pkg::INT_FRAC;
    return t[TW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] mul(input logic signed [TW-1:0] a,
                                               input logic signed [TW-1:0] b);
    return PW'(a) * PW'(b);
  endfunction

  logic [LAT-1:0] vld_q;

  logic signed [PW-1:0] p1_q [4];
  logic signed [TW-1:0] a2_q [4];
  logic signed [PW-1:0] p3_q [8];
  logic signed [TW-1:0] t4_q [8];
  logic signed [SW-1:0] sum_q [e2q_pkg::NUM_COMPS];
  logic signed [TW-1:0] cy_q [2];
  logic signed [TW-1:0] sy_q [2];

  e2q_pkg::trig_t tp;
  e2q_pkg::trig_t ty;
  e2q_pkg::trig_t tr;

  assign tp = trig_i[e2q_pkg::LANE_PITCH];
  assign ty = trig_i[e2q_pkg::LANE_YAW];
  assign tr = trig_i[e2q_pkg::LANE_ROLL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q[RP_CC] <= mul(tr.c, tp.c);
    p1_q[RP_SS] <= mul(tr.s, tp.s);
    p1_q[RP_SC] <= mul(tr.s, tp.c);
    p1_q[RP_CS] <= mul(tr.c, tp.s);
    cy_q[0]     <= ty.c;
    sy_q[0]     <= ty.s;

    for (int k = 0; k < 4; k++) begin
      a2_q[k] <= round_q30(p1_q[k]);
    end
    cy_q[1] <= cy_q[0];
    sy_q[1] <= sy_q[0];

    // Terms in pairs for w, x, y and z; the yaw factor always comes last.
    p3_q[0] <= mul(a2_q[RP_CC], cy_q[1]);
    p3_q[1] <= mul(a2_q[RP_SS], sy_q[1]);
    p3_q[2] <= mul(a2_q[RP_SC], cy_q[1]);
    p3_q[3] <= mul(a2_q[RP_CS], sy_q[1]);
    p3_q[4] <= mul(a2_q[RP_CS], cy_q[1]);
    p3_q[5] <= mul(a2_q[RP_SC], sy_q[1]);
    p3_q[6] <= mul(a2_q[RP_CC], sy_q[1]);
    p3_q[7] <= mul(a2_q[RP_SS], cy_q[1]);

    for (int k = 0; k < 8; k++) begin
      t4_q[k] <= round_q30(p3_q[k]);
    end

    sum_q[e2q_pkg::COMP_W] <= SW'(t4_q[0]) + SW'(t4_q[1]);
    sum_q[e2q_pkg::COMP_X] <= SW'(t4_q[2]) - SW'(t4_q[3]);
    sum_q[e2q_pkg::COMP_Y] <= SW'(t4_q[4]) + SW'(t4_q[5]);
    sum_q[e2q_pkg::COMP_Z] <= SW'(t4_q[6]) - SW'(t4_q[7]);
  end

  assign vld_o = vld_q[LAT-1];
  assign sum_o = sum_q;

endmodule

// ----- src/euler_to_quaternion.sv -----
// Top level: Euler angles (pitch, yaw, roll) to unit quaternion, Z-Y-X convention.
//
// Usage: drive pitch_angle_i, yaw_angle_i and roll_angle_i (signed radians with
// ANGLE_FRAC_BITS fraction bits) and raise start_i; a beat is taken at every
// rising edge where start_i is high and busy_o is low. busy_o never rises, so
// one beat can be taken in every cycle, back to back.
// Each result appears on quat_w_o, quat_x_o, quat_y_o and quat_z_o (signed,
// QUAT_FRAC_BITS fraction bits, saturated to plus or minus one) for exactly one
// cycle with done_o high, in input order.
// The pipeline depth comes from one register stage per modulo-2*pi
// subtraction, two CORDIC iterations per stage over thirty iterations, and
// two rounds of registered multiplies. Throughput is one beat per cycle.
// The receiver cannot stall the outputs; results flow out as they finish.
// Reset (rst_ni low, asynchronous) clears all valid bits, dropping beats in flight.
`include "euler_to_quaternion_defines.svh"

module euler_to_quaternion #(
  parameter int unsigned ANGLE_FRAC_BITS = 13,
  parameter int unsigned QUAT_FRAC_BITS  = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] pitch_angle_i,
  input  logic signed [15:0] yaw_angle_i,
  input  logic signed [15:0] roll_angle_i,
  output logic               done_o,
  output logic signed [15:0] quat_w_o,
  output logic signed [15:0] quat_x_o,
  output logic signed [15:0] quat_y_o,
  output logic signed [15:0] quat_z_o
);

  localparam int unsigned SW  = e2q_pkg::SW;
  localparam int unsigned OW  = SW + 1;
  localparam int unsigned NC  = e2q_pkg::NUM_COMPS;
  localparam int unsigned SH  = e2q_pkg::INT_FRAC - QUAT_FRAC_BITS;
  localparam int unsigned LAT = e2q_pkg::red_steps(ANGLE_FRAC_BITS) +
                                e2q_pkg::TRIG_FIXED_LAT + e2q_pkg::MIX_LAT + 1;

  localparam logic signed [OW-1:0] QONE = OW'(64'd1 << QUAT_FRAC_BITS);

  logic               accept;
  logic signed [15:0] angle [e2q_pkg::NUM_LANES];
  logic               trig_vld;
  e2q_pkg::trig_t     trig [e2q_pkg::NUM_LANES];
  logic               mix_vld;
  logic signed [SW-1:0] sum [NC];
  logic signed [OW-1:0] rnd [NC];
  logic signed [OW-1:0] sat_d [NC];
  logic signed [OW-1:0] sat_q [NC];
  logic               done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign angle[e2q_pkg::LANE_PITCH] = pitch_angle_i;
  assign angle[e2q_pkg::LANE_YAW]   = yaw_angle_i;
  assign angle[e2q_pkg::LANE_ROLL]  = roll_angle_i;

  e2q_trig #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_trig (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (accept),
    .angle_i(angle),
    .vld_o  (trig_vld),
    .trig_o (trig)
  );

  e2q_mix u_mix (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (trig_vld),
    .trig_i(trig),
    .vld_o (mix_vld),
    .sum_o (sum)
  );

  if (SH > 0) begin : g_round
    localparam logic signed [OW-1:0] RND_HALF = OW'(64'd1 << (SH - 1));
    always_comb begin
      for (int c = 0; c < NC; c++) begin
        rnd[c] = (OW'(sum[c]) + RND_HALF) >>> SH;
      end
    end
  end else begin : g_no_round
    always_comb begin
      for (int c = 0; c < NC; c++) begin
        rnd[c] = OW'(sum[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NC; c++) begin
      if (rnd[c] > QONE) begin
        sat_d[c] = QONE;
      end else if (rnd[c] < -QONE) begin
        sat_d[c] = -QONE;
      end else begin
        sat_d[c] = rnd[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= mix_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q <= sat_d;
  end

  // A wide output format cannot hold plus one; the field keeps the low 16 bits.
  assign done_o   = done_q;
  assign quat_w_o = sat_q[e2q_pkg::COMP_W][15:0];
  assign quat_x_o = sat_q[e2q_pkg::COMP_X][15:0];
  assign quat_y_o = sat_q[e2q_pkg::COMP_Y][15:0];
  assign quat_z_o = sat_q[e2q_pkg::COMP_Z][15:0];

  `E2Q_ASSERT_DLY(a_done_follows_start, accept, LAT, done_o,
    "accepted beat did not produce a result after the pipeline latency")
  `E2Q_ASSERT_IMP(a_done_has_start, done_o, $past(accept, LAT),
    "result strobe without an accepted beat one latency earlier")
  `E2Q_ASSERT_IMP(a_w_saturated, done_o,
    (sat_q[e2q_pkg::COMP_W] <= QONE) && (sat_q[e2q_pkg::COMP_W] >= -QONE),
    "w component beyond plus or minus one")
  `E2Q_ASSERT_IMP(a_x_saturated, done_o,
    (sat_q[e2q_pkg::COMP_X] <= QONE) && (sat_q[e2q_pkg::COMP_X] >= -QONE),
    "x component beyond plus or minus one")
  `E2Q_ASSERT_IMP(a_y_saturated, done_o,
    (sat_q[e2q_pkg::COMP_Y] <= QONE) && (sat_q[e2q_pkg::COMP_Y] >= -QONE),
    "y component beyond plus or minus one")
  `E2Q_ASSERT_IMP(a_z_saturated, done_o,
    (sat_q[e2q_pkg::COMP_Z] <= QONE) && (sat_q[e2q_pkg::COMP_Z] >= -QONE),
    "z component beyond plus or minus one")

endmodule
